// ===== rtl/llja_pkg.sv =====
`timescale 1ns / 1ps

package llja_pkg;

    localparam int COUNTERS_DEF = 16;
    localparam int CFG_W        = 5;
    localparam int JOB_W        = 16;
    localparam int TIME_W       = 32;
    localparam int IDX_OUT_W    = 4;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 72;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } llja_state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic update;
    } llja_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } llja_status_t;

endpackage

// ===== rtl/least_loaded_job_assigner.sv =====
`timescale 1ns / 1ps

// Greedy least-loaded scheduler. Each s_ beat carries one job time; the block
// picks the active server with the smallest finish time (lowest index on ties),
// adds the job time with saturation at 2^32-1 and returns one m_ beat with the
// server index, its new finish time and the makespan. An item passes through
// accept, a scan of the finish-time memory over the active servers (one read
// per cycle) and a write back, which waits for a free output register. s_tready
// is high only between items; a finished result waits in an output register, so
// the next job can be taken while it is pending. Reset and new_batch clear the
// per-server valid flags at once, so there is no clearing pass.
module least_loaded_job_assigner #(
    parameter int COUNTERS = llja_pkg::COUNTERS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [llja_pkg::CFG_W-1:0]        cfg_wr_data,   // counter_count
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [llja_pkg::IN_DATA_W-1:0]    s_tdata,       // job_time
    input  logic                              s_tuser,       // new_batch
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // assigned_counter[3:0], counter_finish[35:4], makespan[67:36], zero pad
    output logic [llja_pkg::OUT_DATA_W-1:0]   m_tdata
);

    llja_pkg::llja_cmd_t    cmd;
    llja_pkg::llja_status_t status;

    llja_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    llja_datapath #(
        .COUNTERS (COUNTERS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== rtl/llja_ctrl.sv =====
`timescale 1ns / 1ps

module llja_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  llja_pkg::llja_status_t status,
    output llja_pkg::llja_cmd_t    cmd
);

    llja_pkg::llja_state_t state_reg;
    llja_pkg::llja_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= llja_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            llja_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = llja_pkg::ST_SCAN;
                end
            end
            llja_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = llja_pkg::ST_UPDATE;
                end
            end
            llja_pkg::ST_UPDATE: begin
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = llja_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = llja_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/llja_datapath.sv =====
`timescale 1ns / 1ps

module llja_datapath #(
    parameter int COUNTERS = llja_pkg::COUNTERS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [llja_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic [llja_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [llja_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  llja_pkg::llja_cmd_t               cmd,
    output llja_pkg::llja_status_t            status
);

    localparam int IDX_W = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
    localparam int TW    = llja_pkg::TIME_W;

    logic [TW-1:0]                    mem [COUNTERS];
    logic [COUNTERS-1:0]              valid_reg;
    logic [llja_pkg::CFG_W-1:0]       cfg_reg;
    logic [llja_pkg::JOB_W-1:0]       job_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic [IDX_W-1:0]                 last_reg;
    logic [IDX_W-1:0]                 best_idx_reg;
    logic [TW-1:0]                    best_val_reg;
    logic [TW-1:0]                    rd_data_reg;
    logic [TW-1:0]                    largest_reg;
    logic                             out_valid_reg;
    logic [llja_pkg::IDX_OUT_W-1:0]   out_idx_reg;
    logic [TW-1:0]                    out_finish_reg;
    logic [TW-1:0]                    out_span_reg;

    logic [IDX_W-1:0] last_next;
    logic [IDX_W-1:0] rd_addr;
    logic [TW-1:0]    cur_val;
    logic [TW:0]      sum_wide;
    logic [TW-1:0]    sum_sat;
    logic [TW-1:0]    span_next;
    logic             idx_last;

    always_comb begin
        if (cfg_reg == '0) begin
            last_next = '0;
        end else if (32'(cfg_reg) > 32'(COUNTERS)) begin
            last_next = IDX_W'(COUNTERS - 1);
        end else begin
            last_next = IDX_W'(32'(cfg_reg) - 32'd1);
        end
    end

    assign idx_last = (idx_reg == last_reg);
    assign rd_addr  = cmd.start ? '0 : (idx_last ? idx_reg : idx_reg + 1'b1);
    assign cur_val  = valid_reg[idx_reg] ? rd_data_reg : '0;
    assign sum_wide = {1'b0, best_val_reg} + {{(TW + 1 - llja_pkg::JOB_W){1'b0}}, job_reg};
    assign sum_sat  = sum_wide[TW] ? {TW{1'b1}} : sum_wide[TW-1:0];
    assign span_next = (sum_sat > largest_reg) ? sum_sat : largest_reg;

    assign status.scan_done = idx_last;
    assign status.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.update) begin
            mem[best_idx_reg] <= sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= llja_pkg::CFG_RESET;
            valid_reg     <= '0;
            largest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.start && s_tuser) begin
                valid_reg   <= '0;
                largest_reg <= '0;
            end
            if (cmd.update) begin
                valid_reg[best_idx_reg] <= 1'b1;
                largest_reg             <= span_next;
                out_valid_reg           <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            job_reg  <= s_tdata[llja_pkg::JOB_W-1:0];
            last_reg <= last_next;
            idx_reg  <= '0;
        end
        if (cmd.scan) begin
            if (idx_reg == '0 || cur_val < best_val_reg) begin
                best_idx_reg <= idx_reg;
                best_val_reg <= cur_val;
            end
            if (!idx_last) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (cmd.update) begin
            out_idx_reg    <= llja_pkg::IDX_OUT_W'(32'(best_idx_reg));
            out_finish_reg <= sum_sat;
            out_span_reg   <= span_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_span_reg, out_finish_reg, out_idx_reg};

`ifndef SYNTH
    a_best_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> (idx_reg <= last_reg))
        else $error("scan index past active count");

    a_update_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> out_valid_reg)
        else $error("result not loaded after update");

    a_span_covers_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> (out_span_reg >= out_finish_reg))
        else $error("makespan below server finish time");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !cmd.update)
        else $error("pending result overwritten");
`endif

endmodule

// ===== sim/tb_least_loaded_job_assigner.sv =====
`timescale 1ns / 1ps

module tb_least_loaded_job_assigner;

    localparam int SERVERS    = llja_pkg::COUNTERS_DEF;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int DRAIN_WAIT = SERVERS + 8;

    typedef struct packed {
        logic [llja_pkg::IDX_OUT_W-1:0] server;
        logic [llja_pkg::TIME_W-1:0]    finish;
        logic [llja_pkg::TIME_W-1:0]    span;
    } assignment_t;

    class assignment_book;
        logic [llja_pkg::TIME_W-1:0] finish_at [SERVERS];
        logic [llja_pkg::TIME_W-1:0] makespan;
        logic [llja_pkg::CFG_W-1:0]  servers;
        assignment_t                 due [$];
        int                          faults;

        function new();
            foreach (finish_at[i]) finish_at[i] = '0;
            makespan = '0;
            servers  = llja_pkg::CFG_RESET;
            faults   = 0;
        endfunction

        function void set_servers(logic [llja_pkg::CFG_W-1:0] v);
            servers = v;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_job(logic new_batch, logic [llja_pkg::JOB_W-1:0] job);
            int          active;
            int          best;
            logic [32:0] sum;
            assignment_t a;
            active = (servers == 0) ? 1 : ((servers > SERVERS) ? SERVERS : int'(servers));
            if (new_batch) begin
                foreach (finish_at[i]) finish_at[i] = '0;
                makespan = '0;
            end
            best = 0;
            for (int i = 1; i < active; i++) begin
                if (finish_at[i] < finish_at[best]) best = i;
            end
            sum = {1'b0, finish_at[best]} + 33'(job);
            finish_at[best] = sum[32] ? '1 : sum[31:0];
            if (finish_at[best] > makespan) makespan = finish_at[best];
            a.server = 4'(best);
            a.finish = finish_at[best];
            a.span   = makespan;
            due.push_back(a);
        endfunction

        function void check_assignment(logic [llja_pkg::OUT_DATA_W-1:0] beat);
            assignment_t want;
            assignment_t got;
            got.server = beat[3:0];
            got.finish = beat[35:4];
            got.span   = beat[67:36];
            if (due.size() == 0) begin
                faults++;
                if (faults <= 10) $display("unexpected result beat: %h", beat);
                return;
            end
            want = due.pop_front();
            if (got.server !== want.server || got.finish !== want.finish ||
                got.span !== want.span) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: server %0d/%0d finish %0d/%0d makespan %0d/%0d (exp/act)",
                             want.server, got.server, want.finish, got.finish,
                             want.span, got.span);
            end
        endfunction
    endclass

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [llja_pkg::CFG_W-1:0]        cfg_wr_data = '0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [llja_pkg::IN_DATA_W-1:0]    s_tdata     = '0;
    logic                              s_tuser     = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    logic [llja_pkg::OUT_DATA_W-1:0]   m_tdata;

    logic rx_hold     = 1'b0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   cycle_count = 0;

    assignment_book book = new();

    least_loaded_job_assigner u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_assignment(m_tdata);
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [llja_pkg::JOB_W-1:0] pick_job();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return llja_pkg::JOB_W'($urandom_range(15));
            default: return llja_pkg::JOB_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_job(logic new_batch, logic [llja_pkg::JOB_W-1:0] job);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= job;
        s_tuser  <= new_batch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_job(new_batch, job);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_servers(logic [llja_pkg::CFG_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        book.set_servers(v);
    endtask

    initial begin
        logic [llja_pkg::CFG_W-1:0] count;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset count, extremes of job time, ties, batch clear
        send_job(1'b0, 16'h0000);
        send_job(1'b0, 16'hFFFF);
        send_job(1'b0, 16'h0001);
        send_job(1'b0, 16'h8000);
        send_job(1'b0, 16'h00FF);
        for (int i = 0; i < 12; i++) send_job(1'b0, 16'(1 << i));
        send_job(1'b1, 16'h1234);
        set_servers(5'd0);
        send_job(1'b0, 16'd5);
        send_job(1'b0, 16'd7);
        set_servers(5'd31);
        send_job(1'b0, 16'd9);
        send_job(1'b0, 16'd9);
        send_job(1'b1, 16'd3);

        for (int p = 0; p < 17; p++) begin
            if (p == 0) begin
                tx_idle_pct = 14;
                rx_idle_pct = 75;
            end else if (p == 6) begin
                tx_idle_pct = 75;
                rx_idle_pct = 14;
            end else if (p == 12) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p % 8)
                0:       count = 5'd16;
                1:       count = 5'd3;
                2:       count = 5'd16;
                3:       count = 5'd0;
                4:       count = 5'd31;
                5:       count = 5'd17;
                6:       count = 5'd1;
                default: count = 5'($urandom_range(1, 16));
            endcase
            set_servers(count);
            if (p == 9) begin
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (400) @(posedge aclk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 50; k++) begin
                if (p == 8 && k == 25) wait_drained();
                send_job($urandom_range(99) < 4, pick_job());
            end
        end

        // one server with full job times, then two servers
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_servers(5'd1);
        send_job(1'b1, 16'hFFFF);
        repeat (8) send_job(1'b0, 16'hFFFF);
        set_servers(5'd2);
        send_job(1'b0, 16'd1);
        send_job(1'b0, 16'd1);
        send_job(1'b0, 16'hFFFF);

        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (book.faults == 0 && book.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
